// ===== rtl/min_spanning_tree_weight_unit_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef MIN_SPANNING_TREE_WEIGHT_UNIT_ASSERT_SVH
`define MIN_SPANNING_TREE_WEIGHT_UNIT_ASSERT_SVH

// Next-cycle implication, ignored while reset is held.
`define MSTW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mstw check failed");

// Next-cycle implication that also holds across reset.
`define MSTW_ASSERT_ALWAYS(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mstw check failed");

`endif

// ===== rtl/mstw_pkg.sv =====
`timescale 1ns / 1ps

package mstw_pkg;

  localparam int MAX_NODES_DEF   = 32;
  localparam int MAX_EDGES_DEF   = 64;
  localparam int WEIGHT_BITS_DEF = 16;

  localparam int TOTAL_BITS = 21;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  localparam logic [5:0] NODE_COUNT_RESET = 6'd32;

  typedef struct packed {
    logic [5:0]  end_a;
    logic [5:0]  end_b;
    logic [15:0] edge_weight;
    logic        last_edge;
  } edge_beat_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] total_weight;
    logic                  edges_dropped;
  } result_beat_t;

endpackage

// ===== rtl/min_spanning_tree_weight_unit.sv =====
`timescale 1ns / 1ps

// Minimum spanning forest weight unit.
// Edges arrive on the edge channel (edge_valid / edge_stall / edge_data), one
// beat per cycle while the unit is loading. A beat whose endpoints are not both
// in 1..node_count and at most MAX_NODES is dropped silently; a valid edge that
// finds the store full is dropped and sets edges_dropped. The beat with last_edge
// set closes the graph; edge_stall stays high until its result is registered.
// Computation: the label table is initialized, then one selection pass runs per
// stored edge plus one final pass, each pass reading the stored edges through
// the single read port of the edge store; each selected edge then goes through
// S_LOOK and S_JOIN, and each merge of two trees relabels the label table in
// S_RELABEL.
// The result beat sits in an output register; while the receiver stalls it
// holds, and loading of the next graph proceeds meanwhile. A new result waits
// until the previous beat has been taken.
// node_count is written through cfg_we / cfg_wdata; the user must do so only while
// the unit is idle, which the block itself does not enforce. Synchronous reset
// empties the store, drops any pending result and sets node_count to 32.
module min_spanning_tree_weight_unit #(
  parameter int MAX_NODES   = mstw_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES   = mstw_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = mstw_pkg::WEIGHT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   edge_valid,
  output logic                   edge_stall,
  input  mstw_pkg::edge_beat_t   edge_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output mstw_pkg::result_beat_t result_data,
  input  logic                   cfg_we,
  input  logic [5:0]             cfg_wdata
);

  localparam int NODE_BITS   = $clog2(MAX_NODES);
  localparam int CNT_BITS    = $clog2(MAX_NODES + 1);
  localparam int EDGE_BITS   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FILL_BITS   = $clog2(MAX_EDGES + 1);
  localparam int ENTRY_BITS  = 2 * NODE_BITS + WEIGHT_BITS;
  localparam int KEY_BITS    = WEIGHT_BITS + EDGE_BITS;
  localparam int TOTAL_BITS  = mstw_pkg::TOTAL_BITS;
  localparam int SUM_BITS    = ((WEIGHT_BITS > TOTAL_BITS) ? WEIGHT_BITS : TOTAL_BITS) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_SCAN, S_LOOK, S_JOIN, S_RELABEL, S_DONE
  } state_t;

  state_t state;

  logic [5:0]            node_count;
  logic [FILL_BITS-1:0]  fill;
  logic                  overflow;
  logic [TOTAL_BITS-1:0] total;
  logic [CNT_BITS-1:0]   cnt;
  logic [FILL_BITS-1:0]  scan_idx;
  logic                  rd_valid;
  logic [EDGE_BITS-1:0]  rd_idx;
  logic                  have_prev;
  logic [KEY_BITS-1:0]   prev_key;
  logic                  best_found;
  logic [KEY_BITS-1:0]   best_key;
  logic [NODE_BITS-1:0]  best_a;
  logic [NODE_BITS-1:0]  best_b;
  logic                  rl_valid;
  logic [NODE_BITS-1:0]  rl_addr;
  logic [NODE_BITS-1:0]  old_lbl;
  logic [NODE_BITS-1:0]  new_lbl;

  logic [ENTRY_BITS-1:0] edge_mem [MAX_EDGES];
  logic [ENTRY_BITS-1:0] edge_rdata;

  logic                  accept;
  logic                  edge_ok;
  logic                  load_we;
  logic [ENTRY_BITS-1:0] load_entry;
  logic [WEIGHT_BITS-1:0] cur_w;
  logic [KEY_BITS-1:0]   cur_key;
  logic                  take;
  logic                  scan_issue;
  logic                  rl_issue;
  logic [SUM_BITS-1:0]   sum;
  logic [TOTAL_BITS-1:0] total_next;

  logic                  lbl_we;
  logic [NODE_BITS-1:0]  lbl_waddr;
  logic [NODE_BITS-1:0]  lbl_wdata;
  logic [NODE_BITS-1:0]  lbl_raddr_a;
  logic [NODE_BITS-1:0]  lbl_a;
  logic [NODE_BITS-1:0]  lbl_b;

  assign edge_stall = (state != S_IDLE);
  assign accept     = edge_valid && !edge_stall;

  assign edge_ok = (edge_data.end_a != 6'd0) && (edge_data.end_b != 6'd0) &&
                   (edge_data.end_a <= node_count) && (edge_data.end_b <= node_count) &&
                   (int'(edge_data.end_a) <= MAX_NODES) &&
                   (int'(edge_data.end_b) <= MAX_NODES);
  assign load_we = accept && edge_ok && (fill < FILL_BITS'(MAX_EDGES));
  assign load_entry = {NODE_BITS'(edge_data.end_b - 6'd1),
                       NODE_BITS'(edge_data.end_a - 6'd1),
                       WEIGHT_BITS'(edge_data.edge_weight)};

  // Selection: the next edge is the smallest (weight, slot) key above the one
  // taken last, so each stored edge is visited exactly once in weight order.
  assign cur_w   = edge_rdata[WEIGHT_BITS-1:0];
  assign cur_key = {cur_w, rd_idx};
  assign take    = rd_valid && (!have_prev || cur_key > prev_key) &&
                   (!best_found || cur_key < best_key);
  assign scan_issue = (scan_idx < fill);
  assign rl_issue   = (cnt < CNT_BITS'(MAX_NODES));

  assign sum = SUM_BITS'(total) + SUM_BITS'(best_key[KEY_BITS-1 -: WEIGHT_BITS]);
  assign total_next = (sum > SUM_BITS'(mstw_pkg::TOTAL_MAX)) ? mstw_pkg::TOTAL_MAX
                                                            : sum[TOTAL_BITS-1:0];

  always_comb begin
    lbl_we    = 1'b0;
    lbl_waddr = rl_addr;
    lbl_wdata = new_lbl;
    if (state == S_INIT) begin
      lbl_we    = 1'b1;
      lbl_waddr = cnt[NODE_BITS-1:0];
      lbl_wdata = cnt[NODE_BITS-1:0];
    end else if (state == S_RELABEL) begin
      lbl_we = rl_valid && (lbl_a == old_lbl);
    end
  end

  assign lbl_raddr_a = (state == S_RELABEL) ? cnt[NODE_BITS-1:0] : best_a;

  mstw_labels #(
    .MAX_NODES(MAX_NODES)
  ) u_labels (
    .clk     (clk),
    .we      (lbl_we),
    .waddr   (lbl_waddr),
    .wdata   (lbl_wdata),
    .raddr_a (lbl_raddr_a),
    .raddr_b (best_b),
    .rdata_a (lbl_a),
    .rdata_b (lbl_b)
  );

  always_ff @(posedge clk) begin
    if (load_we) begin
      edge_mem[fill[EDGE_BITS-1:0]] <= load_entry;
    end
    edge_rdata <= edge_mem[scan_idx[EDGE_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      node_count   <= mstw_pkg::NODE_COUNT_RESET;
      fill         <= '0;
      overflow     <= 1'b0;
      total        <= '0;
      result_valid <= 1'b0;
      rd_valid     <= 1'b0;
      rl_valid     <= 1'b0;
      have_prev    <= 1'b0;
      best_found   <= 1'b0;
      cnt          <= '0;
      scan_idx     <= '0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      // In S_DONE the output register is handled by the state arm below.
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (load_we) begin
              fill <= fill + FILL_BITS'(1);
            end else if (edge_ok) begin
              overflow <= 1'b1;
            end
            if (edge_data.last_edge) begin
              cnt   <= '0;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          cnt <= cnt + CNT_BITS'(1);
          if (cnt == CNT_BITS'(MAX_NODES - 1)) begin
            total      <= '0;
            have_prev  <= 1'b0;
            best_found <= 1'b0;
            scan_idx   <= '0;
            rd_valid   <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_valid <= scan_issue;
          rd_idx   <= scan_idx[EDGE_BITS-1:0];
          if (scan_issue) begin
            scan_idx <= scan_idx + FILL_BITS'(1);
          end
          if (take) begin
            best_found <= 1'b1;
            best_key   <= cur_key;
            best_a     <= edge_rdata[WEIGHT_BITS +: NODE_BITS];
            best_b     <= edge_rdata[WEIGHT_BITS + NODE_BITS +: NODE_BITS];
          end
          if (!scan_issue && !rd_valid) begin
            state <= best_found ? S_LOOK : S_DONE;
          end
        end
        S_LOOK: begin
          state <= S_JOIN;
        end
        S_JOIN: begin
          have_prev  <= 1'b1;
          prev_key   <= best_key;
          best_found <= 1'b0;
          scan_idx   <= '0;
          rd_valid   <= 1'b0;
          if (lbl_a != lbl_b) begin
            total    <= total_next;
            old_lbl  <= lbl_b;
            new_lbl  <= lbl_a;
            cnt      <= '0;
            rl_valid <= 1'b0;
            state    <= S_RELABEL;
          end else begin
            state <= S_SCAN;
          end
        end
        S_RELABEL: begin
          rl_valid <= rl_issue;
          rl_addr  <= cnt[NODE_BITS-1:0];
          if (rl_issue) begin
            cnt <= cnt + CNT_BITS'(1);
          end
          if (!rl_issue && !rl_valid) begin
            state <= S_SCAN;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid              <= 1'b1;
            result_data.total_weight  <= total;
            result_data.edges_dropped <= overflow;
            fill                      <= '0;
            overflow                  <= 1'b0;
            state                     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mstw_labels.sv =====
`timescale 1ns / 1ps

// Component label table: one write port, two registered read ports.
module mstw_labels #(
  parameter int MAX_NODES = mstw_pkg::MAX_NODES_DEF,
  localparam int NODE_BITS = $clog2(MAX_NODES)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [NODE_BITS-1:0] waddr,
  input  logic [NODE_BITS-1:0] wdata,
  input  logic [NODE_BITS-1:0] raddr_a,
  input  logic [NODE_BITS-1:0] raddr_b,
  output logic [NODE_BITS-1:0] rdata_a,
  output logic [NODE_BITS-1:0] rdata_b
);

  logic [NODE_BITS-1:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/mstw_checker.sv =====
`timescale 1ns / 1ps
`include "min_spanning_tree_weight_unit_assert.svh"

module mstw_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   edge_valid,
  input logic                   edge_stall,
  input mstw_pkg::edge_beat_t   edge_data,
  input logic                   result_valid,
  input logic                   result_stall,
  input mstw_pkg::result_beat_t result_data
);

  `MSTW_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
  `MSTW_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result_data))
  // Closing a graph starts the computation, so no beat is taken right after.
  `MSTW_ASSERT_NEXT(a_busy_after_last, edge_valid && !edge_stall && edge_data.last_edge,
                    edge_stall)
  `MSTW_ASSERT_ALWAYS(a_reset_clears, rst, !result_valid && !edge_stall)

endmodule

bind min_spanning_tree_weight_unit mstw_checker u_mstw_checker (.*);

// ===== verif/min_spanning_tree_weight_unit_tb.sv =====
`timescale 1ns / 1ps

module min_spanning_tree_weight_unit_tb;

  localparam int NODE_LIMIT  = 32;
  localparam int STORE_DEPTH = 64;
  localparam int STALL_LIMIT = 40000;

  typedef struct {
    logic [4:0]  a;
    logic [4:0]  b;
    logic [15:0] w;
  } stored_edge_t;

  typedef struct {
    logic [5:0]  a;
    logic [5:0]  b;
    logic [15:0] w;
    logic        last;
    logic        typed;
    logic [20:0] total;
    logic        dropped;
  } stim_row_t;

  logic                   clk;
  logic                   rst;
  logic                   edge_valid;
  logic                   edge_stall;
  mstw_pkg::edge_beat_t   edge_data;
  logic                   result_valid;
  logic                   result_stall;
  mstw_pkg::result_beat_t result_data;
  logic                   cfg_we;
  logic [5:0]             cfg_wdata;

  min_spanning_tree_weight_unit dut (
    .clk         (clk),
    .rst         (rst),
    .edge_valid  (edge_valid),
    .edge_stall  (edge_stall),
    .edge_data   (edge_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  // Mirror of the block state.
  stored_edge_t           graph_edges[$];
  logic                   graph_overflow;
  logic [5:0]             node_reg;
  mstw_pkg::result_beat_t forest_totals[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int quiet_cycles;
  int random_items;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic mstw_pkg::result_beat_t forest_weight();
    stored_edge_t           sorted[$];
    stored_edge_t           hold;
    int                     parent[NODE_LIMIT];
    int                     ra;
    int                     rb;
    int                     cur;
    int                     nxt;
    int                     j;
    int                     sum;
    mstw_pkg::result_beat_t res;
    sorted = graph_edges;
    for (int i = 1; i < sorted.size(); i++) begin
      hold = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1].w > hold.w) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = hold;
    end
    for (int v = 0; v < NODE_LIMIT; v++) parent[v] = v;
    sum = 0;
    foreach (sorted[i]) begin
      ra = int'(sorted[i].a);
      while (parent[ra] != ra) ra = parent[ra];
      cur = int'(sorted[i].a);
      while (cur != ra) begin
        nxt = parent[cur];
        parent[cur] = ra;
        cur = nxt;
      end
      rb = int'(sorted[i].b);
      while (parent[rb] != rb) rb = parent[rb];
      cur = int'(sorted[i].b);
      while (cur != rb) begin
        nxt = parent[cur];
        parent[cur] = rb;
        cur = nxt;
      end
      if (ra != rb) begin
        sum += int'(sorted[i].w);
        if (sum > int'(mstw_pkg::TOTAL_MAX)) sum = int'(mstw_pkg::TOTAL_MAX);
        if (ra < rb) parent[rb] = ra;
        else parent[ra] = rb;
      end
    end
    res.total_weight  = sum[20:0];
    res.edges_dropped = graph_overflow;
    return res;
  endfunction

  // Updates the mirror for one accepted beat; returns 1 when a total is due.
  function automatic bit absorb_edge(mstw_pkg::edge_beat_t beat,
                                     output mstw_pkg::result_beat_t res);
    int           n;
    stored_edge_t e;
    n = (node_reg > NODE_LIMIT) ? NODE_LIMIT : int'(node_reg);
    if (beat.end_a >= 1 && beat.end_a <= n && beat.end_b >= 1 && beat.end_b <= n) begin
      if (graph_edges.size() < STORE_DEPTH) begin
        e.a = 5'(beat.end_a - 6'd1);
        e.b = 5'(beat.end_b - 6'd1);
        e.w = beat.edge_weight;
        graph_edges = {graph_edges, e};
      end else begin
        graph_overflow = 1'b1;
      end
    end
    if (!beat.last_edge) return 0;
    res = forest_weight();
    graph_edges.delete();
    graph_overflow = 1'b0;
    return 1;
  endfunction

  task automatic send_edge(mstw_pkg::edge_beat_t beat, bit typed,
                           mstw_pkg::result_beat_t typed_res);
    mstw_pkg::result_beat_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      edge_valid = 1'b0;
      @(negedge clk);
    end
    edge_valid = 1'b1;
    edge_data  = beat;
    do @(posedge clk); while (edge_stall);
    if (absorb_edge(beat, res)) begin
      if (typed) forest_totals = {forest_totals, typed_res};
      else forest_totals = {forest_totals, res};
    end
    @(negedge clk);
  endtask

  task automatic write_node_count(logic [5:0] value);
    edge_valid = 1'b0;
    wait (forest_totals.size() == 0);
    repeat (16) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    node_reg = value;
  endtask

  function automatic logic [5:0] pick_vertex(int n);
    if (n >= 1 && $urandom_range(0, 99) < 85) return 6'($urandom_range(1, n));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [15:0] pick_weight();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 16'($urandom_range(0, 15));
    if (roll < 45) return 16'hFFFF;
    if (roll < 50) return 16'h0000;
    return 16'($urandom);
  endfunction

  task automatic random_graph(int count);
    mstw_pkg::edge_beat_t   beat;
    mstw_pkg::result_beat_t unused;
    int                     n;
    n = (node_reg > NODE_LIMIT) ? NODE_LIMIT : int'(node_reg);
    unused = '0;
    for (int i = 0; i < count; i++) begin
      beat.end_a       = pick_vertex(n);
      beat.end_b       = pick_vertex(n);
      beat.edge_weight = pick_weight();
      beat.last_edge   = (i == count - 1);
      send_edge(beat, 1'b0, unused);
      random_items++;
    end
  endtask

  task automatic random_phase(int target);
    int start;
    int graphs;
    int roll;
    logic [5:0] extremes[5] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2};
    start  = random_items;
    graphs = 0;
    while (random_items - start < target) begin
      if (graphs % 6 == 0) begin
        if ($urandom_range(0, 1)) write_node_count(extremes[$urandom_range(0, 4)]);
        else write_node_count(6'($urandom_range(1, 32)));
      end
      roll = $urandom_range(0, 99);
      if (roll < 85) random_graph($urandom_range(1, 12));
      else if (roll < 95) random_graph($urandom_range(13, 40));
      else random_graph($urandom_range(65, 70));
      graphs++;
    end
  endtask

  // Receiver stall pattern.
  always @(negedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Result check and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if ((edge_valid && !edge_stall) || (result_valid && !result_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
      if (result_valid && !result_stall) begin
        if (forest_totals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: total %0d dropped %0d",
                     result_data.total_weight, result_data.edges_dropped);
        end else begin
          if (result_data.total_weight !== forest_totals[0].total_weight ||
              result_data.edges_dropped !== forest_totals[0].edges_dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected total %0d dropped %0d, got %0d %0d",
                       forest_totals[0].total_weight, forest_totals[0].edges_dropped,
                       result_data.total_weight, result_data.edges_dropped);
          end
          void'(forest_totals.pop_front());
        end
      end
    end
  end

  initial begin
    stim_row_t              rows[$];
    mstw_pkg::edge_beat_t   beat;
    mstw_pkg::result_beat_t typed_res;
    rst            = 1'b1;
    edge_valid     = 1'b0;
    edge_data      = '0;
    result_stall   = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 6'd0;
    node_reg       = mstw_pkg::NODE_COUNT_RESET;
    graph_overflow = 1'b0;
    mismatches     = 0;
    quiet_cycles   = 0;
    random_items   = 0;
    send_idle_pct  = 28;
    recv_idle_pct  = 83;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows with the reset vertex count of 32.
    rows = '{
      '{6'd1,  6'd1,  16'd5,     1'b1, 1'b1, 21'd0,     1'b0},  // self loop alone
      '{6'd1,  6'd32, 16'hFFFF,  1'b1, 1'b1, 21'd65535, 1'b0},  // widest span, heaviest
      '{6'd0,  6'd5,  16'd7,     1'b1, 1'b1, 21'd0,     1'b0},  // vertex zero is invalid
      '{6'd33, 6'd2,  16'd9,     1'b1, 1'b1, 21'd0,     1'b0},  // beyond the count
      '{6'd63, 6'd63, 16'hFFFF,  1'b1, 1'b1, 21'd0,     1'b0},
      '{6'd32, 6'd31, 16'd0,     1'b1, 1'b1, 21'd0,     1'b0},  // zero weight
      '{6'd1,  6'd2,  16'd3,     1'b0, 1'b0, 21'd0,     1'b0},
      '{6'd2,  6'd3,  16'd4,     1'b0, 1'b0, 21'd0,     1'b0},
      '{6'd1,  6'd3,  16'd1,     1'b1, 1'b0, 21'd0,     1'b0},  // triangle
      '{6'd4,  6'd5,  16'd8,     1'b0, 1'b0, 21'd0,     1'b0},
      '{6'd5,  6'd6,  16'd8,     1'b0, 1'b0, 21'd0,     1'b0},
      '{6'd4,  6'd6,  16'd8,     1'b0, 1'b0, 21'd0,     1'b0},  // equal weights
      '{6'd7,  6'd8,  16'hFFFF,  1'b0, 1'b0, 21'd0,     1'b0},
      '{6'd9,  6'd9,  16'd2,     1'b0, 1'b0, 21'd0,     1'b0},
      '{6'd0,  6'd0,  16'd1,     1'b1, 1'b0, 21'd0,     1'b0},  // invalid closer, forest
      '{6'd10, 6'd11, 16'h8000,  1'b0, 1'b0, 21'd0,     1'b0},
      '{6'd11, 6'd10, 16'h7FFF,  1'b1, 1'b0, 21'd0,     1'b0}   // parallel edges
    };
    foreach (rows[i]) begin
      beat.end_a             = rows[i].a;
      beat.end_b             = rows[i].b;
      beat.edge_weight       = rows[i].w;
      beat.last_edge         = rows[i].last;
      typed_res.total_weight  = rows[i].total;
      typed_res.edges_dropped = rows[i].dropped;
      send_edge(beat, rows[i].typed, typed_res);
    end

    // Vertex count of one: only the loop on vertex 1 is stored.
    write_node_count(6'd1);
    beat = '{end_a: 6'd1, end_b: 6'd1, edge_weight: 16'd9, last_edge: 1'b1};
    typed_res = '{total_weight: 21'd0, edges_dropped: 1'b0};
    send_edge(beat, 1'b1, typed_res);
    write_node_count(6'd0);
    beat = '{end_a: 6'd1, end_b: 6'd2, edge_weight: 16'd9, last_edge: 1'b1};
    send_edge(beat, 1'b1, typed_res);

    random_phase(310);
    send_idle_pct = 83;
    recv_idle_pct = 28;
    random_phase(310);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(310);

    edge_valid = 1'b0;
    wait (forest_totals.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== min_spanning_tree_weight_unit.f =====
+incdir+rtl
rtl/mstw_pkg.sv
rtl/mstw_labels.sv
rtl/min_spanning_tree_weight_unit.sv
rtl/mstw_checker.sv
verif/min_spanning_tree_weight_unit_tb.sv
